FILE: hdl/mtr_pkg.sv
// shared types and constants of the mersenne twister random unit
package mtr_pkg;

  // generator geometry
  parameter int unsigned StateDepth  = 624;
  parameter int unsigned ShiftOffset = 397;
  parameter int unsigned IdxW        = 10;
  parameter int unsigned WordW       = 32;
  parameter int unsigned ModW        = 64;
  parameter int unsigned DivCntW     = 5;

  // mt19937 constants
  parameter logic [WordW-1:0] InitMult    = 32'd1812433253;
  parameter logic [WordW-1:0] TwistMatrix = 32'h9908b0df;
  parameter logic [WordW-1:0] TemperB     = 32'h9d2c5680;
  parameter logic [WordW-1:0] TemperC     = 32'hefc60000;
  parameter logic [WordW-1:0] SeedReset   = 32'd5489;

  // index constants
  parameter logic [IdxW-1:0] LastWord = IdxW'(StateDepth - 1);
  parameter logic [IdxW-1:0] DepthIdx = IdxW'(StateDepth);

  // index of the last divider step
  parameter logic [DivCntW-1:0] DivLastStep = DivCntW'(WordW - 1);

  // request as classified by the front end
  typedef struct packed {
    logic             bypass;
    logic [WordW-1:0] divisor;
  } req_t;

  // job handed from the state engine to the divider
  typedef struct packed {
    logic             bypass;
    logic [WordW-1:0] divisor;
    logic [WordW-1:0] word;
  } job_t;

  // state engine sequencing
  typedef enum logic [2:0] {
    ST_SEED,
    ST_IDLE,
    ST_TW_LOAD,
    ST_TW_RUN,
    ST_DELIVER
  } core_state_e;

  // divider sequencing
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

endpackage

FILE: hdl/mtr_front.sv
// input acceptance and modulus classification
module mtr_front (
  input  logic                          in_valid_i,
  input  logic [mtr_pkg::ModW-1:0]      modulus_i,
  input  logic                          q_full_i,
  output logic                          in_stall_o,
  output logic                          push_o,
  output mtr_pkg::req_t                 req_o
);

  // accept whenever the queue has room
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // zero or a modulus beyond 32 bits leaves the word unreduced
  always_comb begin
    req_o.bypass  = (modulus_i == '0) || (modulus_i[mtr_pkg::ModW-1:mtr_pkg::WordW] != '0);
    req_o.divisor = modulus_i[mtr_pkg::WordW-1:0];
  end

endmodule

FILE: hdl/mtr_queue.sv
// short request queue between front end and state engine
module mtr_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mtr_pkg::req_t req_i,
  input  logic          pop_i,
  output mtr_pkg::req_t head_o,
  output logic          valid_o,
  output logic          full_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  mtr_pkg::req_t  entry_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign head_o  = entry_q[rd_ptr_q];
  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == FullCnt);

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= req_i;
    end
  end

  // fill count never passes the depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue fill count above depth");

  // a pop always has an entry behind it
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("queue popped while empty");

endmodule

FILE: hdl/mtr_core.sv
// state engine: seeding, twist, word fetch and tempering
module mtr_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        seed_wr_i,
  input  logic [mtr_pkg::WordW-1:0]   seed_i,
  input  mtr_pkg::req_t               head_i,
  input  logic                        head_valid_i,
  input  logic                        div_ready_i,
  output logic                        pop_o,
  output logic                        start_o,
  output mtr_pkg::job_t               job_o
);

  localparam int unsigned IdxW  = mtr_pkg::IdxW;
  localparam int unsigned WordW = mtr_pkg::WordW;

  // state word memory
  logic [WordW-1:0] mem [mtr_pkg::StateDepth];
  logic [WordW-1:0] rdata_a_q, rdata_b_q;
  logic [IdxW-1:0]  raddr_a, raddr_b, waddr;
  logic [WordW-1:0] wdata;
  logic             we;

  mtr_pkg::core_state_e state_q, state_d;
  logic [IdxW-1:0]  idx_q;
  logic [IdxW-1:0]  cnt_q;
  logic [WordW-1:0] w_q;
  logic [WordW-1:0] a_q;

  logic [WordW-1:0] seed_mix, seed_next;
  logic [WordW-1:0] twist_y, twist_word;
  logic [IdxW-1:0]  nk;
  logic [IdxW:0]    far_sum;
  logic [IdxW-1:0]  far_addr;
  logic [WordW-1:0] t1, t2, t3, t4;

  // seeding recurrence, one word a cycle
  assign seed_mix  = w_q ^ (w_q >> 30);
  assign seed_next = WordW'(seed_mix * mtr_pkg::InitMult) + WordW'(cnt_q);

  // twist of word k from a_q (word k), read port a (word k+1) and read port b (the far word)
  assign twist_y    = {a_q[WordW-1], rdata_a_q[WordW-2:0]};
  assign twist_word = rdata_b_q ^ (twist_y >> 1) ^
                      (twist_y[0] ? mtr_pkg::TwistMatrix : '0);

  // addresses of the next twist step
  assign nk       = (state_q == mtr_pkg::ST_TW_LOAD) ? '0 : cnt_q + IdxW'(1);
  assign far_sum  = {1'b0, nk} + (IdxW + 1)'(mtr_pkg::ShiftOffset);
  assign far_addr = (far_sum >= (IdxW + 1)'(mtr_pkg::StateDepth)) ?
                    IdxW'(far_sum - (IdxW + 1)'(mtr_pkg::StateDepth)) :
                    far_sum[IdxW-1:0];

  // tempering of the fetched word
  assign t1 = rdata_a_q ^ (rdata_a_q >> 11);
  assign t2 = t1 ^ ((t1 << 7) & mtr_pkg::TemperB);
  assign t3 = t2 ^ ((t2 << 15) & mtr_pkg::TemperC);
  assign t4 = t3 ^ (t3 >> 18);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mtr_pkg::ST_SEED: begin
        if (cnt_q == mtr_pkg::LastWord) state_d = mtr_pkg::ST_IDLE;
      end
      mtr_pkg::ST_IDLE: begin
        if (head_valid_i && div_ready_i) begin
          state_d = (idx_q == mtr_pkg::DepthIdx) ? mtr_pkg::ST_TW_LOAD : mtr_pkg::ST_DELIVER;
        end
      end
      mtr_pkg::ST_TW_LOAD: state_d = mtr_pkg::ST_TW_RUN;
      mtr_pkg::ST_TW_RUN: begin
        if (cnt_q == mtr_pkg::LastWord) state_d = mtr_pkg::ST_IDLE;
      end
      mtr_pkg::ST_DELIVER: state_d = mtr_pkg::ST_IDLE;
      default: state_d = mtr_pkg::ST_IDLE;
    endcase
    if (seed_wr_i) state_d = mtr_pkg::ST_SEED;
  end

  // memory control and job handoff
  always_comb begin
    raddr_a     = '0;
    raddr_b     = '0;
    we          = 1'b0;
    waddr       = cnt_q;
    wdata       = twist_word;
    pop_o       = 1'b0;
    start_o     = 1'b0;
    job_o.bypass  = head_i.bypass;
    job_o.divisor = head_i.divisor;
    job_o.word    = t4;
    unique case (state_q)
      mtr_pkg::ST_SEED: begin
        we    = 1'b1;
        wdata = (cnt_q == '0) ? seed_i : seed_next;
      end
      mtr_pkg::ST_IDLE: begin
        raddr_a = (idx_q == mtr_pkg::DepthIdx) ? '0 : idx_q;
      end
      mtr_pkg::ST_TW_LOAD: begin
        raddr_a = nk + IdxW'(1);
        raddr_b = far_addr;
      end
      mtr_pkg::ST_TW_RUN: begin
        we      = 1'b1;
        raddr_a = (nk == mtr_pkg::LastWord) ? '0 : nk + IdxW'(1);
        raddr_b = far_addr;
      end
      mtr_pkg::ST_DELIVER: begin
        pop_o   = 1'b1;
        start_o = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mtr_pkg::ST_SEED;
      idx_q   <= mtr_pkg::DepthIdx;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (seed_wr_i) begin
        cnt_q <= '0;
      end else begin
        unique case (state_q)
          mtr_pkg::ST_SEED: begin
            cnt_q <= cnt_q + IdxW'(1);
            if (cnt_q == mtr_pkg::LastWord) idx_q <= mtr_pkg::DepthIdx;
          end
          mtr_pkg::ST_TW_LOAD: cnt_q <= '0;
          mtr_pkg::ST_TW_RUN: begin
            cnt_q <= cnt_q + IdxW'(1);
            if (cnt_q == mtr_pkg::LastWord) idx_q <= '0;
          end
          mtr_pkg::ST_DELIVER: idx_q <= idx_q + IdxW'(1);
          default: cnt_q <= cnt_q;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == mtr_pkg::ST_SEED) w_q <= wdata;
    if (state_q == mtr_pkg::ST_TW_LOAD || state_q == mtr_pkg::ST_TW_RUN) a_q <= rdata_a_q;
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_a_q <= mem[raddr_a];
    rdata_b_q <= mem[raddr_b];
  end

  // read index stays within the state depth
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= mtr_pkg::DepthIdx)
    else $error("read index beyond state depth");

  // a job only goes out with a request present and the divider free
  a_start_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_o |-> (head_valid_i && div_ready_i))
    else $error("job started without request or free divider");

endmodule

FILE: hdl/mtr_div.sv
// radix-2 remainder unit with output register
module mtr_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  mtr_pkg::job_t              job_i,
  output logic                       ready_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [mtr_pkg::WordW-1:0]  value_o
);

  localparam int unsigned WordW = mtr_pkg::WordW;

  mtr_pkg::div_state_e st_q, st_d;
  logic [mtr_pkg::DivCntW-1:0] cnt_q;
  logic [WordW-1:0] rem_q, dvd_q, dsr_q;
  logic             byp_q;
  logic             out_valid_q;
  logic [WordW-1:0] value_q;

  logic [WordW:0]   trial;
  logic             fits;
  logic [WordW-1:0] rem_d;
  logic             slot_free;
  logic             load_out;

  // one remainder bit per cycle
  assign trial = {rem_q, dvd_q[WordW-1]};
  assign fits  = (trial >= {1'b0, dsr_q});
  assign rem_d = fits ? WordW'(trial - {1'b0, dsr_q}) : trial[WordW-1:0];

  assign slot_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      mtr_pkg::DIV_IDLE: begin
        if (start_i) st_d = job_i.bypass ? mtr_pkg::DIV_DONE : mtr_pkg::DIV_RUN;
      end
      mtr_pkg::DIV_RUN: begin
        if (cnt_q == mtr_pkg::DivLastStep) st_d = mtr_pkg::DIV_DONE;
      end
      mtr_pkg::DIV_DONE: begin
        if (slot_free) st_d = mtr_pkg::DIV_IDLE;
      end
      default: st_d = mtr_pkg::DIV_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    ready_o  = (st_q == mtr_pkg::DIV_IDLE);
    load_out = (st_q == mtr_pkg::DIV_DONE) && slot_free;
  end

  // control and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= mtr_pkg::DIV_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // operand and remainder registers
  always_ff @(posedge clk_i) begin
    if (st_q == mtr_pkg::DIV_IDLE && start_i) begin
      dvd_q <= job_i.word;
      dsr_q <= job_i.divisor;
      byp_q <= job_i.bypass;
      rem_q <= '0;
      cnt_q <= '0;
    end else if (st_q == mtr_pkg::DIV_RUN) begin
      rem_q <= rem_d;
      dvd_q <= dvd_q << 1;
      cnt_q <= cnt_q + mtr_pkg::DivCntW'(1);
    end
    if (load_out) value_q <= byp_q ? dvd_q : rem_q;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  // a finished remainder is below its divisor
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == mtr_pkg::DIV_DONE && !byp_q) |-> rem_q < dsr_q)
    else $error("remainder not below divisor");

  // zero divisors never reach the iteration
  a_no_zero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == mtr_pkg::DIV_RUN) |-> dsr_q != '0)
    else $error("iteration with zero divisor");

endmodule

FILE: hdl/mersenne_twister_random_mod_unit.sv
// top level of the mt19937 generator with per-transaction modulus reduction
//
// Input channel: in_valid_i / in_stall_o carry modulus_i; each transaction
// returns one value_o on the output channel out_valid_o / out_stall_i.
// A modulus of zero, or one above 32 bits, returns the tempered word as is.
// Configuration: APB write of the seed at byte address 0 rebuilds the
// 624-word state and forces a twist before the next word.
// Reset loads seed 5489 and runs the same seeding pass; requests
// are queued but not served until it ends.
// Reduced words pass through the 32-step radix-2 remainder unit, while
// unreduced words skip it. Every 624th word adds a twist pass over the
// state memory. Transactions go one at a time through the remainder
// unit; a two-entry queue keeps accepting during that work.
// When the receiver stalls, the result holds in the output register and
// the next result waits in the remainder unit; the queue fills, then
// in_stall_o rises.
module mersenne_twister_random_mod_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [mtr_pkg::ModW-1:0]   modulus_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [mtr_pkg::WordW-1:0]  value_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam logic RegSeed = 1'b0;

  logic                 seed_wr;
  logic [31:0]          seed_q;
  logic                 push, pop, q_full, q_valid;
  mtr_pkg::req_t        req, head;
  logic                 start, div_ready;
  mtr_pkg::job_t        job;

  // configuration port
  assign pready  = 1'b1;
  assign seed_wr = psel && penable && pwrite && (paddr[2] == RegSeed);
  assign prdata  = (paddr[2] == RegSeed) ? seed_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= mtr_pkg::SeedReset;
    end else if (seed_wr) begin
      seed_q <= pwdata;
    end
  end

  // front end
  mtr_front u_front (
    .in_valid_i (in_valid_i),
    .modulus_i  (modulus_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .req_o      (req)
  );

  // request queue
  mtr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (req),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  // state engine
  mtr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_wr_i    (seed_wr),
    .seed_i       (seed_q),
    .head_i       (head),
    .head_valid_i (q_valid),
    .div_ready_i  (div_ready),
    .pop_o        (pop),
    .start_o      (start),
    .job_o        (job)
  );

  // remainder unit and output register
  mtr_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .job_i       (job),
    .ready_o     (div_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o)
  );

endmodule

FILE: dv/testbench.sv
// testbench for the mt19937 generator with per-transaction modulus reduction
`timescale 1ns / 1ps

module testbench;

  // geometry taken from the package
  localparam int unsigned WordW       = mtr_pkg::WordW;
  localparam int unsigned ModW        = mtr_pkg::ModW;
  localparam int unsigned StateDepth  = mtr_pkg::StateDepth;
  localparam int unsigned ShiftOffset = mtr_pkg::ShiftOffset;

  // register byte addresses
  localparam logic [2:0] SeedAddr  = 3'd0;
  localparam logic [2:0] SpareAddr = 3'd4;

  // run bounds
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned PrintCap = 20;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [ModW-1:0]   modulus_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [WordW-1:0]  value_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  mersenne_twister_random_mod_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .modulus_i   (modulus_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // generator state as the block should hold it
  logic [WordW-1:0] mt_words [StateDepth];
  int unsigned      mt_pos;
  logic [WordW-1:0] mt_seed;
  int unsigned      mt_twists;
  int unsigned      seeds_loaded;

  // transaction bookkeeping
  logic [ModW-1:0]  mod_pending [$];
  logic [WordW-1:0] value_due [$];
  int unsigned      req_issued;
  int unsigned      req_taken;
  int unsigned      results_seen;
  int unsigned      mismatches;
  int unsigned      cycles;
  bit               in_fire;
  bit               out_fire;
  bit               in_rush;
  bit               out_rush;
  int unsigned      in_wait;
  int unsigned      out_hold = 3;

  // rebuild the word array from a seed
  function automatic void mt_reseed(logic [WordW-1:0] s);
    logic [WordW-1:0] w;
    w = s;
    mt_words[0] = w;
    for (int unsigned i = 1; i < StateDepth; i++) begin
      w = WordW'(mtr_pkg::InitMult * (w ^ (w >> 30)) + WordW'(i));
      mt_words[i] = w;
    end
    mt_pos = StateDepth;
    mt_seed = s;
    seeds_loaded++;
  endfunction

  // in-place twist of the whole array
  function automatic void mt_twist();
    logic [WordW-1:0] y;
    logic [WordW-1:0] far;
    for (int unsigned k = 0; k < StateDepth; k++) begin
      y = {mt_words[k][31], mt_words[(k + 1) % StateDepth][30:0]};
      far = mt_words[(k + ShiftOffset) % StateDepth];
      mt_words[k] = far ^ (y >> 1) ^ (y[0] ? mtr_pkg::TwistMatrix : '0);
    end
    mt_pos = 0;
    mt_twists++;
  endfunction

  // next tempered word, reduced by the transaction's modulus
  function automatic logic [WordW-1:0] mt_draw(logic [ModW-1:0] m);
    logic [WordW-1:0] y;
    logic [ModW-1:0]  r;
    if (mt_pos >= StateDepth) mt_twist();
    y = mt_words[mt_pos];
    mt_pos++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & mtr_pkg::TemperB);
    y = y ^ ((y << 15) & mtr_pkg::TemperC);
    y = y ^ (y >> 18);
    r = {32'd0, y};
    if (m != '0) r = r % m;
    return r[WordW-1:0];
  endfunction

  // idle count for one transaction, with occasional stretches of none
  function automatic int unsigned pick_delay(inout bit rush);
    if ($urandom_range(0, 31) == 0) rush = !rush;
    return rush ? 0 : $urandom_range(0, 6);
  endfunction

  // random modulus spread over the interesting ranges
  function automatic logic [ModW-1:0] rand_modulus();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return '0;
    else if (pick < 35) return ModW'($urandom_range(1, 16));
    else if (pick < 65) return {32'd0, $urandom()};
    else if (pick < 75) return 64'd1 << $urandom_range(0, 63);
    else if (pick < 80) return {32'd0, 32'hffff_ffff - $urandom_range(0, 3)};
    else return {$urandom(), $urandom()};
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < PrintCap) $display("error: %s", msg);
    mismatches++;
  endtask

  // input side: predict on every accepted transaction
  always @(posedge clk_i) begin
    in_fire = rst_ni && in_valid_i && !in_stall_o;
    if (in_fire) begin
      value_due.push_back(mt_draw(modulus_i));
      req_taken++;
    end
  end

  // input driver, fed from the pending queue
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (in_wait > 0) begin
        in_valid_i <= 1'b0;
        in_wait--;
      end else if (mod_pending.size() != 0) begin
        modulus_i <= mod_pending.pop_front();
        in_valid_i <= 1'b1;
        in_wait = pick_delay(in_rush);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output monitor: compare against the oldest prediction
  always @(posedge clk_i) begin
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    if (out_fire) begin
      results_seen++;
      if (value_due.size() == 0) begin
        report_mismatch($sformatf("result %0d value %h with nothing expected",
                                  results_seen, value_o));
      end else if (value_o !== value_due[0]) begin
        report_mismatch($sformatf("result %0d value %h, expected %h",
                                  results_seen, value_o, value_due[0]));
        void'(value_due.pop_front());
      end else begin
        void'(value_due.pop_front());
      end
      out_hold = pick_delay(out_rush);
    end
  end

  // output stall driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_hold > 0) begin
        out_stall_i <= 1'b1;
        out_hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               value_due.size());
      $display("status: fail");
      $finish;
    end
  end

  // one apb transfer: setup phase then access phase
  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] data, output logic [31:0] rd);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // write the seed, mirror it and read it back
  task automatic load_seed(input logic [31:0] s);
    logic [31:0] rd;
    apb_access(1'b1, SeedAddr, s, rd);
    mt_reseed(s);
    apb_access(1'b0, SeedAddr, '0, rd);
    if (rd !== mt_seed)
      report_mismatch($sformatf("seed reads back %h, expected %h", rd, mt_seed));
  endtask

  task automatic push_req(input logic [ModW-1:0] m);
    mod_pending.push_back(m);
    req_issued++;
  endtask

  // wait until every transaction has been taken and answered
  task automatic wait_idle();
    @(negedge clk_i);
    while (req_taken != req_issued || value_due.size() != 0) @(negedge clk_i);
  endtask

  // stimulus sequence
  initial begin
    logic [31:0] rd;
    mt_reseed(mtr_pkg::SeedReset);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: modulus extremes on the reset seed
    push_req(64'd0);
    push_req(64'd1);
    push_req(64'd2);
    push_req(64'd3);
    push_req(64'd10);
    push_req(64'd7);
    push_req(64'd1000);
    push_req(64'h0000_0000_8000_0000);
    push_req(64'h0000_0000_ffff_fffe);
    push_req(64'h0000_0000_ffff_ffff);
    push_req(64'h0000_0001_0000_0000);
    push_req(64'h0000_0001_0000_0001);
    push_req(64'h8000_0000_0000_0000);
    push_req(64'hffff_ffff_ffff_ffff);
    wait_idle();

    // directed: seed zero, and a write to an unused address is ignored
    load_seed(32'd0);
    apb_access(1'b1, SpareAddr, 32'hdead_beef, rd);
    push_req(64'd0);
    push_req(64'd1);
    push_req(64'd5);
    push_req(64'hffff_ffff_ffff_ffff);
    wait_idle();

    // directed: all-ones seed
    load_seed(32'hffff_ffff);
    push_req(64'd0);
    push_req(64'd3);
    push_req(64'h0000_0001_0000_0000);
    wait_idle();

    // random: a long run that crosses the second twist
    load_seed($urandom());
    for (int i = 0; i < 640; i++) push_req(rand_modulus());
    wait_idle();

    // random: short runs over further seeds
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: load_seed(32'd1);
        1: load_seed(32'h8000_0000);
        default: load_seed($urandom());
      endcase
      for (int i = 0; i < 40; i++) push_req(rand_modulus());
      wait_idle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    $display("%0d transactions checked over %0d seed loads and %0d twist passes",
             results_seen, seeds_loaded, mt_twists);
    $display("%0d mismatches in %0d cycles", mismatches, cycles);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: mersenne_twister_random_mod_unit.f
hdl/mtr_pkg.sv
hdl/mtr_front.sv
hdl/mtr_queue.sv
hdl/mtr_core.sv
hdl/mtr_div.sv
hdl/mersenne_twister_random_mod_unit.sv
dv/testbench.sv
